@@ src/afs_pkg.sv @@
package afs_pkg;

  // Default sizes of the filter table
  localparam int CAPACITY_DEF       = 32;
  localparam int MAX_ADDR_BYTES_DEF = 8;

  // Fixed widths of the stream and configuration fields
  localparam int ADDR_W   = 64;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int LEN_W    = 4;

  // Reset value of the compare length, in bytes
  localparam logic [LEN_W-1:0] ADDR_LEN_RST = 4'd6;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd3;

  // Byte mask for a compare length; zero acts as one byte, long lengths saturate
  function automatic logic [ADDR_W-1:0] byte_mask(input logic [LEN_W-1:0] len,
                                                   input int max_bytes);
    int n;
    logic [ADDR_W-1:0] m;
    n = int'(len);
    if (n < 1) n = 1;
    if (n > max_bytes) n = max_bytes;
    m = '0;
    for (int b = 0; b < ADDR_W / 8; b++) begin
      if (b < n) m[8*b +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

@@ src/afs_ram.sv @@
module afs_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/address_filter_set_unit.sv @@
// Exact-match address filter table. Each input word carries an operation
// (insert, remove, lookup, clear) and an address; only the low bytes given by
// the configured compare length are stored and compared. Every word gives one
// result word with a status, a found flag and the entry count after the
// operation. Keys sit in a single-port-read RAM that one comparator walks
// entry by entry, so an insert, remove or lookup runs through the accept,
// scan (one RAM read per entry), drain and finish states before the next word
// is accepted; a clear goes straight from accept to finish. A result word still
// waiting on out_tready holds the finish state. The table needs no clearing pass
// after reset: per-entry valid flops mark which keys are live.
module address_filter_set_unit #(
  parameter int CAPACITY       = afs_pkg::CAPACITY_DEF,
  parameter int MAX_ADDR_BYTES = afs_pkg::MAX_ADDR_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration: compare length in bytes
  input  logic                          cfg_wr_en,
  input  logic [afs_pkg::LEN_W-1:0]     cfg_wr_data,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [afs_pkg::ADDR_W-1:0]    in_tdata,  // [63:0] address
  input  logic [afs_pkg::OP_W-1:0]      in_tuser,  // [1:0] operation
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata  // [1:0] status, [2] found,
                                                   // [8:3] entry_count, zero fill
);

  localparam int KEY_W = 8 * MAX_ADDR_BYTES;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t                           state_r;
  logic [afs_pkg::LEN_W-1:0]        key_len_r;
  logic [afs_pkg::OP_W-1:0]         op_r;
  logic [KEY_W-1:0]                 key_r;
  logic [KEY_W-1:0]                 mask_r;
  logic [IDX_W-1:0]                 idx_r;
  logic                             cmp_vld_r;
  logic [IDX_W-1:0]                 cmp_idx_r;
  logic                             found_r;
  logic                             free_vld_r;
  logic [IDX_W-1:0]                 free_idx_r;
  logic [CAPACITY-1:0]              valid_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [CNT_W-1:0]                 cnt_nxt;
  logic                             out_tvalid_r;
  logic [15:0]                      out_tdata_r;

  logic [afs_pkg::ADDR_W-1:0]       mask_full;
  logic [KEY_W-1:0]                 rd_key;
  logic                             hit;
  logic                             out_free;
  logic                             ram_we;
  logic [afs_pkg::STATUS_W-1:0]     status;
  logic [CNT_W+afs_pkg::COUNT_W-1:0] cnt_ext;

  assign mask_full = afs_pkg::byte_mask(key_len_r, MAX_ADDR_BYTES);
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  // Key store, read one entry per scan cycle
  afs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (key_r),
    .re    (state_r == S_SCAN),
    .raddr (idx_r),
    .rdata (rd_key)
  );

  // Compare the entry read last cycle
  assign hit = cmp_vld_r && valid_r[cmp_idx_r] && (((rd_key ^ key_r) & mask_r) == '0);

  // Write the new key when an insert finds room
  assign ram_we = (state_r == S_FINISH) && out_free && (op_r == afs_pkg::OP_INSERT) &&
                  !found_r && free_vld_r;
  assign cnt_nxt = ram_we ? cnt_r + CNT_ONE : cnt_r;

  // Result status
  always_comb begin
    status = afs_pkg::ST_OK;
    unique case (op_r)
      afs_pkg::OP_INSERT: begin
        if (found_r)          status = afs_pkg::ST_PRESENT;
        else if (!free_vld_r) status = afs_pkg::ST_TABLE_FULL;
      end
      afs_pkg::OP_REMOVE: begin
        if (!found_r) status = afs_pkg::ST_NOT_FOUND;
      end
      afs_pkg::OP_LOOKUP: status = afs_pkg::ST_OK;
      afs_pkg::OP_CLEAR:  status = afs_pkg::ST_OK;
      default:            status = afs_pkg::ST_OK;
    endcase
  end

  assign cnt_ext = {{afs_pkg::COUNT_W{1'b0}}, cnt_nxt};

  // Sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      key_len_r    <= afs_pkg::ADDR_LEN_RST;
      cmp_vld_r    <= 1'b0;
      valid_r      <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_len_r <= cfg_wr_data;
      end

      // Drop the result once taken, unless the finish step loads the next one
      if (out_tvalid_r && out_tready && state_r != S_FINISH) begin
        out_tvalid_r <= 1'b0;
      end

      cmp_vld_r <= (state_r == S_SCAN);
      cmp_idx_r <= idx_r;

      // Track hits, remove matches and remember the first free entry
      if (cmp_vld_r) begin
        if (hit) begin
          found_r <= 1'b1;
          if (op_r == afs_pkg::OP_REMOVE) begin
            valid_r[cmp_idx_r] <= 1'b0;
            cnt_r              <= cnt_r - CNT_ONE;
          end
        end
        if (!valid_r[cmp_idx_r] && !free_vld_r) begin
          free_vld_r <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= in_tuser;
            key_r      <= in_tdata[KEY_W-1:0] & mask_full[KEY_W-1:0];
            mask_r     <= mask_full[KEY_W-1:0];
            idx_r      <= '0;
            found_r    <= 1'b0;
            free_vld_r <= 1'b0;
            if (in_tuser == afs_pkg::OP_CLEAR) begin
              valid_r <= '0;
              cnt_r   <= '0;
              state_r <= S_FINISH;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            if (ram_we) begin
              valid_r[free_idx_r] <= 1'b1;
              cnt_r               <= cnt_nxt;
            end
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {7'd0, cnt_ext[afs_pkg::COUNT_W-1:0], found_r, status};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Count always matches the number of live entries
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(valid_r)))
    else $error("entry count out of step with valid flags");

  // Count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_CAP)
    else $error("entry count above capacity");

  // A clear empties the table at once
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == afs_pkg::OP_CLEAR) |=> (valid_r == '0))
    else $error("clear left valid entries");

  // An insert only fills an entry that was free
  a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !valid_r[free_idx_r])
    else $error("insert overwrote a live entry");

  // No new word is taken while a scan is running
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_vld_r || state_r == S_SCAN) |-> !in_tready)
    else $error("input accepted during scan");

endmodule

@@ dv/afs_filter_checker.sv @@
`timescale 1ns / 100ps

// Watches the configuration, request and result channels of the address
// filter, keeps its own copy of the table, and checks every result word.
module afs_filter_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [afs_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [afs_pkg::ADDR_W-1:0] in_tdata,
  input  logic [afs_pkg::OP_W-1:0]   in_tuser,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [15:0]                out_tdata,
  output int                         fail_count,
  output int                         pending,
  output int                         results_checked,
  output int                         full_seen
);

  typedef struct packed {
    logic [afs_pkg::STATUS_W-1:0] status;
    logic                         found;
    logic [afs_pkg::COUNT_W-1:0]  count;
  } filter_result_t;

  // Shadow table
  bit                         table_live [afs_pkg::CAPACITY_DEF];
  logic [afs_pkg::ADDR_W-1:0] table_key  [afs_pkg::CAPACITY_DEF];
  int                         live_count;
  logic [afs_pkg::LEN_W-1:0]  cmp_len;

  filter_result_t    expected_q[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    full_seen       = 0;
  end

  // Mask of the bytes that take part in a compare at the current length
  function automatic logic [afs_pkg::ADDR_W-1:0] compare_mask(
      input logic [afs_pkg::LEN_W-1:0] len);
    int nbytes;
    nbytes = int'(len);
    if (nbytes < 1) nbytes = 1;
    if (nbytes > afs_pkg::MAX_ADDR_BYTES_DEF) nbytes = afs_pkg::MAX_ADDR_BYTES_DEF;
    if (nbytes >= 8) return '1;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  // Apply one request to the shadow table and return the result it gives
  function automatic filter_result_t apply_request(input logic [afs_pkg::OP_W-1:0] op,
                                                   input logic [afs_pkg::ADDR_W-1:0] addr);
    logic [afs_pkg::ADDR_W-1:0] mask;
    logic [afs_pkg::ADDR_W-1:0] key;
    filter_result_t             res;
    int                         free_slot;
    mask      = compare_mask(cmp_len);
    key       = addr & mask;
    res       = '0;
    free_slot = -1;
    res.status = afs_pkg::ST_OK;

    // Scan for a match and the lowest free slot
    if (op != afs_pkg::OP_CLEAR) begin
      for (int i = 0; i < afs_pkg::CAPACITY_DEF; i++) begin
        if (table_live[i]) begin
          if (((table_key[i] ^ key) & mask) == '0) res.found = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
    end

    case (op)
      afs_pkg::OP_INSERT: begin
        if (res.found) begin
          res.status = afs_pkg::ST_PRESENT;
        end else if (free_slot < 0) begin
          res.status = afs_pkg::ST_TABLE_FULL;
        end else begin
          table_live[free_slot] = 1'b1;
          table_key[free_slot]  = key;
          live_count++;
        end
      end
      afs_pkg::OP_REMOVE: begin
        if (res.found) begin
          // Drop every entry that agrees on the compared bytes
          for (int i = 0; i < afs_pkg::CAPACITY_DEF; i++) begin
            if (table_live[i] && ((table_key[i] ^ key) & mask) == '0) begin
              table_live[i] = 1'b0;
              if (live_count > 0) live_count--;
            end
          end
        end else begin
          res.status = afs_pkg::ST_NOT_FOUND;
        end
      end
      afs_pkg::OP_LOOKUP: begin
      end
      default: begin
        for (int i = 0; i < afs_pkg::CAPACITY_DEF; i++) table_live[i] = 1'b0;
        live_count = 0;
        res.found  = 1'b0;
      end
    endcase

    res.count = live_count[afs_pkg::COUNT_W-1:0];
    return res;
  endfunction

  task automatic report(input string what, input longint want_v, input longint got_v);
    $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, want_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    filter_result_t want;
    if (!rst_n) begin
      cmp_len    = afs_pkg::ADDR_LEN_RST;
      live_count = 0;
      for (int i = 0; i < afs_pkg::CAPACITY_DEF; i++) table_live[i] = 1'b0;
      expected_q.delete();
    end else begin
      // Check a result word against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("result word with nothing expected", 0, longint'(out_tdata));
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          if (want.status == afs_pkg::ST_TABLE_FULL) full_seen++;
          if (out_tdata[1:0] !== want.status)
            report("status", longint'(want.status), longint'(out_tdata[1:0]));
          if (out_tdata[2] !== want.found)
            report("found", longint'(want.found), longint'(out_tdata[2]));
          if (out_tdata[8:3] !== want.count)
            report("entry_count", longint'(want.count), longint'(out_tdata[8:3]));
        end
      end
      // Predict the result of an accepted request word
      if (in_tvalid && in_tready) expected_q.push_back(apply_request(in_tuser, in_tdata));
      // Hold the new compare length
      if (cfg_wr_en) cmp_len = cfg_wr_data;
    end
    pending = expected_q.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = afs_pkg::CAPACITY_DEF + 8;
  localparam int NUM_PHASES  = 13;
  localparam int HIST_DEPTH  = 48;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [afs_pkg::LEN_W-1:0]  cfg_wr_data;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [afs_pkg::ADDR_W-1:0] in_tdata;   // [63:0] address
  logic [afs_pkg::OP_W-1:0]   in_tuser;   // [1:0] operation
  logic                       out_tvalid;
  logic                       out_tready;
  logic [15:0]                out_tdata;  // [1:0] status, [2] found, [8:3] entry_count

  int fail_count;
  int pending;
  int results_checked;
  int full_seen;

  bit                         quiet;
  int                         op_tally [4];
  int                         len_writes;
  logic [afs_pkg::ADDR_W-1:0] addr_hist[$];
  int                         cycles;

  logic [afs_pkg::LEN_W-1:0]  len_plan [NUM_PHASES] = '{4'd6, 4'd0, 4'd8, 4'd1, 4'd15,
                                                       4'd3, 4'd2, 4'd8, 4'd4, 4'd5,
                                                       4'd7, 4'd12, 4'd1};

  address_filter_set_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  afs_filter_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .full_seen       (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("tb NOT OK");
    $finish;
  end

  // Result side: stall a random number of cycles before each word
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Send one request word after a random gap; returns at the falling edge after accept
  task automatic send_word(input logic [afs_pkg::OP_W-1:0] op,
                           input logic [afs_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    op_tally[op]++;
    addr_hist.push_back(addr);
    if (addr_hist.size() > HIST_DEPTH) void'(addr_hist.pop_front());
  endtask

  // Drain all results, let the block go idle, then write the compare length
  task automatic write_len(input logic [afs_pkg::LEN_W-1:0] len);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    len_writes++;
  endtask

  // Draw an address: reuse a recent one, a near-collision, an extreme or a fresh one
  function automatic logic [afs_pkg::ADDR_W-1:0] pick_addr(input int reuse_pct);
    logic [afs_pkg::ADDR_W-1:0] a;
    int                         r;
    int                         b;
    r = $urandom_range(0, 99);
    if (r < reuse_pct && addr_hist.size() > 0) begin
      a = addr_hist[$urandom_range(0, addr_hist.size() - 1)];
      // disturb the upper bytes now and then
      if ($urandom_range(0, 2) == 0) begin
        b = $urandom_range(1, 7);
        a = a ^ ({$urandom, $urandom} << (8 * b));
      end
    end else if (r < reuse_pct + 15) begin
      a = {$urandom, $urandom};
      a[7:0] = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 0) a[63:8] = '0;
    end else if (r < reuse_pct + 20) begin
      a = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end else begin
      a = {$urandom, $urandom};
    end
    return a;
  endfunction

  initial begin : stimulus
    int                        r;
    int                        n;
    logic [afs_pkg::OP_W-1:0]  op;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = afs_pkg::OP_LOOKUP;
    quiet       = 1'b0;
    len_writes  = 0;
    for (int i = 0; i < 4; i++) op_tally[i] = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default six-byte compare, ignored upper bytes, ok, present and not-found statuses
    send_word(afs_pkg::OP_LOOKUP, 64'h0);
    send_word(afs_pkg::OP_INSERT, 64'h0);
    send_word(afs_pkg::OP_INSERT, '1);
    send_word(afs_pkg::OP_INSERT, 64'hAB00_0000_0000_0000);
    send_word(afs_pkg::OP_INSERT, 64'h0000_1122_3344_5566);
    send_word(afs_pkg::OP_LOOKUP, 64'h7700_1122_3344_5566);
    send_word(afs_pkg::OP_LOOKUP, 64'h0000_1122_3344_5567);
    send_word(afs_pkg::OP_REMOVE, 64'h1);
    send_word(afs_pkg::OP_REMOVE, 64'hFF00_FFFF_FFFF_FFFF);
    send_word(afs_pkg::OP_LOOKUP, '1);
    send_word(afs_pkg::OP_CLEAR,  '1);
    send_word(afs_pkg::OP_REMOVE, 64'h0);

    // Full-width keys that share their low byte
    write_len(4'd8);
    send_word(afs_pkg::OP_INSERT, 64'h0102_0304_0506_0708);
    send_word(afs_pkg::OP_INSERT, 64'hFF02_0304_0506_0708);
    send_word(afs_pkg::OP_INSERT, 64'h0000_0000_0000_0708);
    send_word(afs_pkg::OP_LOOKUP, 64'h0102_0304_0506_0708);

    // Zero length acts as one byte: all three now match, remove drops them all
    write_len(4'd0);
    send_word(afs_pkg::OP_LOOKUP, 64'h08);
    send_word(afs_pkg::OP_INSERT, 64'hEE08);
    send_word(afs_pkg::OP_REMOVE, 64'h1108);

    // Length above the maximum saturates
    write_len(4'd15);
    send_word(afs_pkg::OP_INSERT, '1);
    send_word(afs_pkg::OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(afs_pkg::OP_LOOKUP, '1);

    // Random phases: fill runs that reach table full, and mixed churn
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_len(len_plan[p]);
      quiet = ($urandom_range(0, 3) == 0);
      if (p % 2 == 0) begin
        send_word(afs_pkg::OP_CLEAR, pick_addr(0));
        repeat (60) begin
          r  = $urandom_range(0, 99);
          op = (r < 85) ? afs_pkg::OP_INSERT :
               (r < 95) ? afs_pkg::OP_LOOKUP : afs_pkg::OP_REMOVE;
          send_word(op, pick_addr(op == afs_pkg::OP_INSERT ? 20 : 70));
        end
      end else begin
        n = $urandom_range(35, 55);
        repeat (n) begin
          r  = $urandom_range(0, 99);
          op = (r < 40) ? afs_pkg::OP_INSERT :
               (r < 65) ? afs_pkg::OP_REMOVE :
               (r < 95) ? afs_pkg::OP_LOOKUP : afs_pkg::OP_CLEAR;
          send_word(op, pick_addr(60));
        end
      end
    end

    // Wait out the last results
    in_tvalid <= 1'b0;
    quiet = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("sent %0d insert, %0d remove, %0d lookup, %0d clear words over %0d length writes",
             op_tally[afs_pkg::OP_INSERT], op_tally[afs_pkg::OP_REMOVE],
             op_tally[afs_pkg::OP_LOOKUP], op_tally[afs_pkg::OP_CLEAR], len_writes);
    $display("checked %0d result words, %0d of them table-full", results_checked, full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/afs_pkg.sv
src/afs_ram.sv
src/address_filter_set_unit.sv
dv/afs_filter_checker.sv
dv/tb.sv
